/* hdl/pcpa_pkg.sv */
// Shared types, sizes and codes of the per-CPU page allocator.
package pcpa_pkg;

    // Sizes of the lists and of the link store.
    localparam int NUM_CPUS  = 8;
    localparam int NUM_PAGES = 32768;
    localparam int CPU_W     = 3;
    localparam int SLOT_W    = $clog2(NUM_PAGES);
    localparam int LINK_W    = SLOT_W + 1;

    // Address and register widths.
    localparam int ADDR_W       = 32;
    localparam int PAGE_SHIFT   = 12;
    localparam int PAGE_W       = ADDR_W - PAGE_SHIFT;
    localparam int TOP_W        = PAGE_W + 1;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = TOP_W;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 40;

    // Request codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_PAGE   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [PAGE_W-1:0] FIRST_PAGE_RESET = 20'd524288;
    localparam logic [TOP_W-1:0]  TOP_PAGE_RESET   = 21'd557056;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [CPU_W-1:0]  cpu_t;

endpackage

/* hdl/pcpa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/per_cpu_page_allocator_with_steal_top.sv */
// Top level of the per-CPU page allocator with stealing between lists.
//
// Requests arrive on the slave stream. tuser carries the command (allocate
// or free), tdata carries the requesting CPU and the byte address of the page
// to free. Every request produces exactly one result word on the master
// stream with a status, the allocated page address and a stolen flag.
//
// A free checks the address and pushes the page in the cycle it is accepted;
// its result is valid in the following cycle, and the next request may
// follow immediately. An allocate that finds a non-empty list reads the next
// link of the chosen list head from the link RAM; the block waits in S_POP
// for the registered read data and takes no new request until it finishes.
//
// The result sits in an output register. A new request is taken while the
// block is idle and that register is empty or being emptied in the same
// cycle; when the receiver stalls, input stalls too. After reset all lists
// are empty and the page registers hold their default values; the link RAM
// needs no clearing, as only pushed entries are ever read. Configuration
// must be written while idle; the block itself does not enforce this.
module per_cpu_page_allocator_with_steal_top
    import pcpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata fields from bit 0: cpu[2:0], phys_addr[34:3], zero padding.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0: cmd[0].
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata fields from bit 0: status[1:0], page_addr[33:2], stolen[34],
    // zero padding.
    output logic [OUT_DATA_W-1:0] m_tdata
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    state_t state_reg;

    logic [PAGE_W-1:0] first_page_reg;
    logic [TOP_W-1:0]  top_page_reg;

    slot_t             head_reg     [NUM_CPUS];
    logic [NUM_CPUS-1:0] nonempty_reg;

    cpu_t              pop_cpu_reg;
    slot_t             pop_slot_reg;
    logic              pop_stolen_reg;

    logic              m_tvalid_reg;
    logic [1:0]        out_status_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_stolen_reg;

    // Request fields.
    logic              in_cmd;
    cpu_t              in_cpu;
    logic [ADDR_W-1:0] in_addr;
    logic              in_fire;
    logic              out_free;

    assign in_cmd  = s_tuser;
    assign in_cpu  = s_tdata[CPU_W-1:0];
    assign in_addr = s_tdata[CPU_W +: ADDR_W];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;

    // Free address check and slot number.
    logic [PAGE_W-1:0] in_page;
    logic [PAGE_W-1:0] in_diff;
    logic              addr_bad;
    logic              cpu_valid;

    always_comb
    begin
        in_page   = in_addr[ADDR_W-1:PAGE_SHIFT];
        in_diff   = in_page - first_page_reg;
        addr_bad  = (in_addr[PAGE_SHIFT-1:0] != '0)
                 || (in_page < first_page_reg)
                 || ({1'b0, in_page} >= top_page_reg)
                 || ({1'b0, in_diff} >= TOP_W'(NUM_PAGES));
        cpu_valid = ({1'b0, in_cpu} < (CPU_W + 1)'(NUM_CPUS));
    end

    // Choice of the list to pop: own list first, else the lowest other one.
    logic own_hit;
    logic steal_hit;
    cpu_t steal_cpu;

    always_comb
    begin
        own_hit   = cpu_valid && nonempty_reg[in_cpu[$clog2(NUM_CPUS)-1:0]];
        steal_hit = 1'b0;
        steal_cpu = '0;
        for (int c = NUM_CPUS - 1; c >= 0; c--)
        begin
            if (nonempty_reg[c] && (CPU_W'(c) != in_cpu))
            begin
                steal_hit = 1'b1;
                steal_cpu = CPU_W'(c);
            end
        end
    end

    // Link RAM access: push writes at acceptance, pop reads at acceptance.
    logic  mem_we;
    slot_t mem_waddr;
    link_t mem_wdata;
    logic  mem_re;
    slot_t mem_raddr;
    link_t mem_rdata;
    cpu_t  pop_cpu;

    always_comb
    begin
        pop_cpu   = own_hit ? in_cpu : steal_cpu;
        mem_we    = in_fire && (in_cmd == CMD_FREE) && !addr_bad && cpu_valid;
        mem_waddr = in_diff[SLOT_W-1:0];
        mem_wdata = nonempty_reg[in_cpu[$clog2(NUM_CPUS)-1:0]]
                  ? {1'b0, head_reg[in_cpu[$clog2(NUM_CPUS)-1:0]]} + LINK_W'(1)
                  : '0;
        mem_re    = in_fire && (in_cmd == CMD_ALLOC) && (own_hit || steal_hit);
        mem_raddr = head_reg[pop_cpu[$clog2(NUM_CPUS)-1:0]];
    end

    pcpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result register occupancy: loaded by a finished request, cleared when taken.
    logic result_load;
    logic m_tvalid_next;

    always_comb
    begin
        result_load   = (state_reg == S_POP) || (in_fire && !mem_re);
        m_tvalid_next = result_load || (m_tvalid_reg && !m_tready);
    end

    // Address of the page being popped, rebuilt from the current first page.
    logic [PAGE_W-1:0] pop_page;
    assign pop_page = first_page_reg + PAGE_W'(pop_slot_reg);

    // Control, list state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_page_reg <= FIRST_PAGE_RESET;
            top_page_reg   <= TOP_PAGE_RESET;
            for (int c = 0; c < NUM_CPUS; c++)
            begin
                head_reg[c] <= '0;
            end
            nonempty_reg   <= '0;
            pop_cpu_reg    <= '0;
            pop_slot_reg   <= '0;
            pop_stolen_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_addr_reg   <= '0;
            out_stolen_reg <= 1'b0;
        end
        else
        begin
            // Configuration writes.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FIRST_PAGE: first_page_reg <= cfg_wdata[PAGE_W-1:0];
                    REG_TOP_PAGE:   top_page_reg   <= cfg_wdata[TOP_W-1:0];
                    default: ;
                endcase
            end

            m_tvalid_reg <= m_tvalid_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (in_cmd == CMD_FREE)
                        begin
                            // Push onto the requester's list.
                            out_status_reg <= addr_bad ? STATUS_BAD : STATUS_OK;
                            out_addr_reg   <= '0;
                            out_stolen_reg <= 1'b0;
                            if (mem_we)
                            begin
                                head_reg[in_cpu[$clog2(NUM_CPUS)-1:0]] <= mem_waddr;
                                nonempty_reg[in_cpu[$clog2(NUM_CPUS)-1:0]] <= 1'b1;
                            end
                        end
                        else if (own_hit || steal_hit)
                        begin
                            // Start a pop; the link arrives next cycle.
                            state_reg      <= S_POP;
                            pop_cpu_reg    <= pop_cpu;
                            pop_slot_reg   <= mem_raddr;
                            pop_stolen_reg <= !own_hit;
                        end
                        else
                        begin
                            out_status_reg <= STATUS_EMPTY;
                            out_addr_reg   <= '0;
                            out_stolen_reg <= 1'b0;
                        end
                    end
                end
                S_POP:
                begin
                    // Finish the pop: advance the head or empty the list.
                    state_reg      <= S_IDLE;
                    out_status_reg <= STATUS_OK;
                    out_addr_reg   <= {pop_page, PAGE_SHIFT'(0)};
                    out_stolen_reg <= pop_stolen_reg;
                    if (mem_rdata == '0)
                    begin
                        nonempty_reg[pop_cpu_reg[$clog2(NUM_CPUS)-1:0]] <= 1'b0;
                    end
                    else
                    begin
                        head_reg[pop_cpu_reg[$clog2(NUM_CPUS)-1:0]] <=
                            SLOT_W'(mem_rdata - LINK_W'(1));
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_DATA_W - ADDR_W - 3)'(0), out_stolen_reg,
                       out_addr_reg, out_status_reg};

    // A pop always finds the result register empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> !m_tvalid_reg)
        else $error("pop finishing while a result is still pending");

    // The link RAM is never written and read in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("link RAM written and read in one cycle");

    // A free or an empty allocate yields its result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !mem_re) |=> m_tvalid_reg)
        else $error("single-cycle request produced no result");

    // A pop only starts from a non-empty list.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> nonempty_reg[pop_cpu[$clog2(NUM_CPUS)-1:0]])
        else $error("pop started on an empty list");

endmodule
